// File: design/efs_pkg.sv
// Shared types, constants and kernels of the 3x3 edge filter.
// Used by the interfaces, the controller, the datapath and the top level.
package efs_pkg;

   localparam int PIX_W      = 8;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = 13;
   localparam int POS_W      = 14;
   localparam int SUM_W      = 12;
   localparam int SQ_W       = 21;
   localparam int ROOT_IN_W  = 16;
   localparam int ROOT_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [1:0] mode_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam mode_type MODE_SOBEL   = 2'd0;
   localparam mode_type MODE_PREWITT = 2'd1;
   localparam mode_type MODE_LAPLACE = 2'd2;

   localparam csr_index_type REG_MODE   = 2'd0;
   localparam csr_index_type REG_WIDTH  = 2'd1;
   localparam csr_index_type REG_HEIGHT = 2'd2;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   typedef logic signed [3:0] coef_type;
   typedef coef_type kernel_type [9];

   localparam kernel_type SOBEL_X = '{-4'sd1, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd0,
                                      4'sd1, 4'sd2, 4'sd1};
   localparam kernel_type SOBEL_Y = '{-4'sd1, 4'sd0, 4'sd1, -4'sd2, 4'sd0, 4'sd2,
                                      -4'sd1, 4'sd0, 4'sd1};
   localparam kernel_type PREWITT_X = '{-4'sd1, -4'sd1, -4'sd1, 4'sd0, 4'sd0, 4'sd0,
                                        4'sd1, 4'sd1, 4'sd1};
   localparam kernel_type PREWITT_Y = '{4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd0, -4'sd1,
                                        4'sd1, 4'sd0, -4'sd1};
   localparam kernel_type LAPLACE = '{4'sd0, -4'sd1, 4'sd0, -4'sd1, 4'sd4, -4'sd1,
                                      4'sd0, -4'sd1, 4'sd0};

   typedef struct packed {
      logic clear;
      logic accept;
      logic shift;
      logic mask;
      logic corr;
      logic square;
      logic root_start;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic has_result;
      logic root_done;
      logic out_free;
   } status_type;

endpackage

// File: design/efs_pixel_if.sv
// Input channel of the edge filter: valid/ready handshake with pixel payload.
// Depends on efs_pkg.
interface efs_pixel_if;
   logic              valid;
   logic              ready;
   efs_pkg::pix_type  pixel;
   logic              filler;

   modport source (output valid, output pixel, output filler, input ready);
   modport sink (input valid, input pixel, input filler, output ready);
endinterface

// File: design/efs_edge_if.sv
// Result channel of the edge filter: valid/ready handshake with edge payload.
// Depends on efs_pkg.
interface efs_edge_if;
   logic              valid;
   logic              ready;
   efs_pkg::pix_type  edge_value;
   logic              frame_end;

   modport source (output valid, output edge_value, output frame_end, input ready);
   modport sink (input valid, input edge_value, input frame_end, output ready);
endinterface

// File: design/efs_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on efs_pkg.
module efs_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [efs_pkg::ROOT_IN_W-1:0]      radicand,
   output logic                               done,
   output logic [efs_pkg::ROOT_W-1:0]         root
);
   import efs_pkg::*;

   logic                  busy_ff;
   logic [ROOT_W-1:0]     step_ff;
   logic [ROOT_IN_W-1:0]  rad_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [ROOT_W-1:0]     trial;
   logic [ROOT_IN_W-1:0]  trial_sq;

   assign trial    = root_ff | step_ff;
   assign trial_sq = ROOT_IN_W'(trial) * ROOT_IN_W'(trial);
   assign done     = busy_ff & step_ff[0];
   assign root     = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= {1'b1, {(ROOT_W-1){1'b0}}};
      end else if (busy_ff) begin
         step_ff <= step_ff >> 1;
         if (step_ff[0]) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
      end else if (busy_ff && trial_sq <= rad_ff) begin
         root_ff <= trial;
      end
   end

   a_root_exact: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy_ff) && !$past(reset)) |->
         (({9'b0, root_ff} * {9'b0, root_ff}) <= {1'b0, rad_ff}) &&
         ((({9'b0, root_ff} + 17'd1) * ({9'b0, root_ff} + 17'd1)) > {1'b0, rad_ff}))
      else $error("square root result is not the floor root");

   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot(step_ff))
      else $error("square root step marker lost while busy");

endmodule

// File: design/efs_ctrl.sv
// Controller of the edge filter: sequences clearing, fetch, window, filter and root steps.
// Depends on efs_pkg; drives efs_datapath through cmd_type and reads status_type.
module efs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  efs_pkg::status_type  status,
   output efs_pkg::cmd_type     cmd
);
   import efs_pkg::*;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_SHIFT  = 10'b0000000100,
      ST_MASK   = 10'b0000001000,
      ST_CORR   = 10'b0000010000,
      ST_SQUARE = 10'b0000100000,
      ST_ROOT   = 10'b0001000000,
      ST_WAIT   = 10'b0010000000,
      ST_DONE   = 10'b0100000000,
      ST_SPARE  = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_MASK;
         end
         ST_MASK: begin
            if (status.has_result) begin
               cmd.mask = 1'b1;
               state_in = ST_CORR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CORR: begin
            cmd.corr = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_then_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.shift)
      else $error("accepted transaction was not shifted into the window");

   a_root_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.root_done |-> (state_ff == ST_WAIT))
      else $error("square root finished outside the wait step");

endmodule

// File: design/efs_datapath.sv
// Datapath of the edge filter: line stores, window, position counters, kernels,
// magnitude and output register. Depends on efs_pkg and efs_sqrt.
module efs_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  efs_pkg::cmd_type                    cmd,
   output efs_pkg::status_type                 status,
   input  efs_pkg::mode_type                   mode,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_width,
   input  logic [efs_pkg::HEIGHT_W-1:0]        eff_height,
   input  logic                                restart,
   input  efs_pkg::pix_type                    req_pixel,
   input  logic                                req_filler,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output efs_pkg::pix_type                    rsp_edge_value,
   output logic                                rsp_frame_end
);
   import efs_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   pix_type upper_mem [MAX_WIDTH];
   pix_type lower_mem [MAX_WIDTH];

   logic [CW-1:0]    clr_ff;
   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [CW-1:0]    col_sel;
   logic [CW-1:0]    addr_ff;
   pix_type          pix_ff;
   pix_type          upper_rd_ff;
   pix_type          lower_rd_ff;
   logic             mem_we;
   logic [CW-1:0]    mem_addr;
   pix_type          upper_wd;
   pix_type          lower_wd;

   pix_type                 win_ff [3][3];
   logic                    at_col0;
   logic                    row_end;
   logic signed [POS_W-1:0] cr_in;
   logic signed [POS_W-1:0] cr_ff;
   logic signed [POS_W-1:0] h_last;
   logic [WW-1:0]           cc_in;
   logic [WW-1:0]           cc_ff;
   logic                    fe_in;
   logic                    fe_ff;
   logic                    has_result_ff;

   pix_type                 g_in [9];
   pix_type                 g_ff [9];
   logic signed [SUM_W-1:0] gx_in;
   logic signed [SUM_W-1:0] gy_in;
   logic signed [SUM_W-1:0] gx_ff;
   logic signed [SUM_W-1:0] gy_ff;
   logic signed [2*SUM_W-1:0] px;
   logic signed [2*SUM_W-1:0] py;
   logic [SQ_W-1:0]         sqx_ff;
   logic [SQ_W-1:0]         sqy_ff;
   logic signed [SUM_W:0]   dbl;
   pix_type                 lap_in;
   pix_type                 lap_ff;
   logic [SQ_W:0]           sumsq;
   logic                    sat_ff;
   logic                    root_done;
   logic [ROOT_W-1:0]       root;
   logic                    is_lap;
   pix_type                 edge_in;

   logic                    rsp_valid_ff;
   pix_type                 edge_ff;
   logic                    fe_out_ff;

   // Line stores: clearing sweep after reset, then one write per transaction.
   assign col_sel  = (WW'(col_ff) >= eff_width) ? '0 : col_ff;
   assign mem_we   = cmd.clear | cmd.shift;
   assign mem_addr = cmd.clear ? clr_ff : addr_ff;
   assign upper_wd = cmd.clear ? '0 : lower_rd_ff;
   assign lower_wd = cmd.clear ? '0 : pix_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[mem_addr] <= upper_wd;
         lower_mem[mem_addr] <= lower_wd;
      end
      if (cmd.accept) begin
         upper_rd_ff <= upper_mem[col_sel];
         lower_rd_ff <= lower_mem[col_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff  <= req_filler ? '0 : req_pixel;
         addr_ff <= col_sel;
      end
   end

   // Position of the window center and the next counter values.
   assign at_col0 = (addr_ff == '0);
   assign cr_in   = POS_W'({1'b0, row_ff}) - (at_col0 ? POS_W'(2) : POS_W'(1));
   assign cc_in   = at_col0 ? (eff_width - WW'(1)) : (WW'(addr_ff) - WW'(1));
   assign h_last  = POS_W'({1'b0, eff_height}) - POS_W'(1);
   assign fe_in   = (cr_in == h_last) && (cc_in == eff_width - WW'(1));
   assign row_end = (WW'(addr_ff) + WW'(1)) >= eff_width;

   always_comb begin
      if (fe_in) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end else begin
         col_in = addr_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.shift) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_result_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (cmd.shift) begin
         has_result_ff <= !cr_in[POS_W-1];
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= upper_rd_ff;
         win_ff[1][2] <= lower_rd_ff;
         win_ff[2][2] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         cr_ff <= cr_in;
         cc_ff <= cc_in;
         fe_ff <= fe_in;
      end
   end

   // Positions outside the image read as zero.
   always_comb begin
      int rr;
      int cl;
      rr = 0;
      cl = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rr = int'(cr_ff) + i - 1;
            cl = int'(cc_ff) + j - 1;
            if (rr >= 0 && rr < int'(eff_height) && cl >= 0 && cl < int'(eff_width)) begin
               g_in[i*3+j] = win_ff[i][j];
            end else begin
               g_in[i*3+j] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mask) begin
         g_ff <= g_in;
      end
   end

   // Correlation with the kernel pair of the current mode; the Laplace mode uses its single kernel.
   always_comb begin
      coef_type cx;
      coef_type cy;
      gx_in = '0;
      gy_in = '0;
      cx    = '0;
      cy    = '0;
      for (int k = 0; k < 9; k++) begin
         case (mode)
            MODE_SOBEL: begin
               cx = SOBEL_X[k];
               cy = SOBEL_Y[k];
            end
            MODE_PREWITT: begin
               cx = PREWITT_X[k];
               cy = PREWITT_Y[k];
            end
            default: begin
               cx = LAPLACE[k];
               cy = '0;
            end
         endcase
         gx_in = gx_in + SUM_W'(cx) * $signed({4'b0, g_ff[k]});
         gy_in = gy_in + SUM_W'(cy) * $signed({4'b0, g_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.corr) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   assign px  = gx_ff * gx_ff;
   assign py  = gy_ff * gy_ff;
   assign dbl = {gx_ff, 1'b0};

   always_comb begin
      if (dbl[SUM_W]) begin
         lap_in = '0;
      end else if (dbl[SUM_W-1:PIX_W] != '0) begin
         lap_in = '1;
      end else begin
         lap_in = dbl[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sqx_ff <= px[SQ_W-1:0];
         sqy_ff <= py[SQ_W-1:0];
         lap_ff <= lap_in;
      end
   end

   assign sumsq = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         sat_ff <= (sumsq[SQ_W:ROOT_IN_W] != '0);
      end
   end

   efs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (sumsq[ROOT_IN_W-1:0]),
      .done     (root_done),
      .root     (root)
   );

   // Output register.
   assign is_lap  = (mode != MODE_SOBEL) && (mode != MODE_PREWITT);
   assign edge_in = is_lap ? lap_ff : (sat_ff ? '1 : root);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         edge_ff   <= edge_in;
         fe_out_ff <= fe_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = edge_ff;
   assign rsp_frame_end  = fe_out_ff;

   assign status.clear_done = (clr_ff == CW'(MAX_WIDTH - 1));
   assign status.has_result = has_result_ff;
   assign status.root_done  = root_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift && fe_in) |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters did not return to zero after the last frame position");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load)
      else $error("output register overwritten before its transaction");

endmodule

// File: design/edge_filter_3x3_stream_unit.sv
// A transaction that yields no result passes the shift and mask steps only; one that yields a
// result also passes correlation, squaring and the 8-step square-root unit, and its result is
// registered once the output register is free.
// Results wait in an output register while the next input transaction is taken.
// After reset both line stores are cleared across all MAX_WIDTH addresses with req.ready low;
// configuration writes are taken during that pass. Depends on efs_pkg, efs_ctrl, efs_datapath.
module edge_filter_3x3_stream_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   efs_pixel_if.sink                            req,
   efs_edge_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  efs_pkg::csr_index_type               csr_index,
   input  logic [efs_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import efs_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);

   mode_type             mode_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic [HEIGHT_W-1:0]  height_ff;
   logic [WW-1:0]        eff_width;
   logic [HEIGHT_W-1:0]  eff_height;
   logic                 restart;
   logic                 ready;
   cmd_type              cmd;
   status_type           status;
   logic                 out_valid;
   pix_type              out_edge;
   logic                 out_frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SOBEL;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_wdata[1:0];
            REG_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            REG_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign restart = csr_wr_en && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT));

   always_comb begin
      if (width_ff == '0) begin
         eff_width = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_ff);
      end
   end

   always_comb begin
      if (height_ff == '0) begin
         eff_height = HEIGHT_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         eff_height = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_height = height_ff;
      end
   end

   efs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   efs_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .mode           (mode_ff),
      .eff_width      (eff_width),
      .eff_height     (eff_height),
      .restart        (restart),
      .req_pixel      (req.pixel),
      .req_filler     (req.filler),
      .rsp_valid      (out_valid),
      .rsp_ready      (rsp.ready),
      .rsp_edge_value (out_edge),
      .rsp_frame_end  (out_frame_end)
   );

   assign req.ready      = ready;
   assign rsp.valid      = out_valid;
   assign rsp.edge_value = out_edge;
   assign rsp.frame_end  = out_frame_end;

endmodule

// File: bench/efs_edge_checker.sv
// Checker for the 3x3 edge filter: follows the pixel, edge and register traffic,
// keeps its own line stores and window, and compares each edge transaction.
// Depends on efs_pkg, efs_pixel_if and efs_edge_if.
module efs_edge_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   efs_pixel_if                                 pixel_mon,
   efs_edge_if                                  edge_mon,
   input  logic                                 csr_wr_en,
   input  efs_pkg::csr_index_type               csr_index,
   input  logic [efs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   failures,
   output int                                   pending_edges
);
   timeunit 1ns;
   timeprecision 1ps;
   import efs_pkg::*;

   typedef struct packed {
      pix_type edge_value;
      logic    frame_end;
   } edge_item_type;

   edge_item_type expected_edges[$];

   pix_type                line_upper [MAX_WIDTH];
   pix_type                line_lower [MAX_WIDTH];
   pix_type                window [3][3];
   int                     col_pos;
   int                     row_pos;
   mode_type               cur_mode;
   logic [WIDTH_W-1:0]     reg_width;
   logic [HEIGHT_W-1:0]    reg_height;
   int                     mismatches;
   int                     edge_count;

   function automatic pix_type edge_magnitude(input int gx, input int gy);
      int sq;
      int root;
      int trial;
      sq = gx * gx + gy * gy;
      if (sq >= 65536) begin
         return 8'hFF;
      end
      root = 0;
      for (int b = 7; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= sq) begin
            root = trial;
         end
      end
      return pix_type'(root);
   endfunction

   task automatic filter_pixel(input pix_type pixel, input logic filler);
      int w;
      int h;
      int c;
      int cr;
      int cc;
      int rr;
      int cl;
      int lap;
      int g [9];
      pix_type v;
      pix_type top_pix;
      pix_type mid_pix;
      edge_item_type item;
      w = (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width));
      h = (reg_height == 0) ? 1 : ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height));
      v = filler ? '0 : pixel;
      c = (col_pos >= w) ? 0 : col_pos;

      top_pix = line_upper[c];
      mid_pix = line_lower[c];
      line_upper[c] = mid_pix;
      line_lower[c] = v;
      for (int i = 0; i < 3; i++) begin
         window[i][0] = window[i][1];
         window[i][1] = window[i][2];
      end
      window[0][2] = top_pix;
      window[1][2] = mid_pix;
      window[2][2] = v;

      // The window center trails the newest pixel by one row and one column.
      if (c >= 1) begin
         cr = row_pos - 1;
         cc = c - 1;
      end else begin
         cr = row_pos - 2;
         cc = w - 1;
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end else begin
         col_pos = c + 1;
      end
      if (cr < 0) begin
         return;
      end

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rr = cr - 1 + i;
            cl = cc - 1 + j;
            g[i * 3 + j] = (rr >= 0 && rr < h && cl >= 0 && cl < w) ? int'(window[i][j]) : 0;
         end
      end

      case (cur_mode)
         MODE_SOBEL: begin
            item.edge_value = edge_magnitude((g[6] + 2 * g[7] + g[8]) - (g[0] + 2 * g[1] + g[2]),
                                             (g[2] + 2 * g[5] + g[8]) - (g[0] + 2 * g[3] + g[6]));
         end
         MODE_PREWITT: begin
            item.edge_value = edge_magnitude((g[6] + g[7] + g[8]) - (g[0] + g[1] + g[2]),
                                             (g[0] + g[3] + g[6]) - (g[2] + g[5] + g[8]));
         end
         default: begin
            lap = 2 * (4 * g[4] - g[1] - g[3] - g[5] - g[7]);
            item.edge_value = (lap < 0) ? 8'h00 : ((lap > 255) ? 8'hFF : pix_type'(lap));
         end
      endcase

      item.frame_end = (cr == h - 1 && cc == w - 1);
      if (item.frame_end) begin
         col_pos = 0;
         row_pos = 0;
      end
      expected_edges.push_back(item);
   endtask

   always @(posedge clock) begin : track
      edge_item_type want;
      if (reset) begin
         for (int k = 0; k < MAX_WIDTH; k++) begin
            line_upper[k] = '0;
            line_lower[k] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               window[i][j] = '0;
            end
         end
         col_pos = 0;
         row_pos = 0;
         cur_mode = MODE_SOBEL;
         reg_width = WIDTH_RESET;
         reg_height = HEIGHT_RESET;
         expected_edges.delete();
         mismatches = 0;
         edge_count = 0;
      end else begin
         if (edge_mon.valid && edge_mon.ready) begin
            if (expected_edges.size() == 0) begin
               if (mismatches < 10) begin
                  $display("Unexpected edge transaction %0d: edge_value=%0d frame_end=%0b",
                           edge_count, edge_mon.edge_value, edge_mon.frame_end);
               end
               mismatches++;
            end else begin
               want = expected_edges.pop_front();
               if (edge_mon.edge_value !== want.edge_value ||
                   edge_mon.frame_end !== want.frame_end) begin
                  if (mismatches < 10) begin
                     $display("Edge transaction %0d: expected edge_value=%0d frame_end=%0b,",
                              edge_count, want.edge_value, want.frame_end,
                              " got edge_value=%0d frame_end=%0b",
                              edge_mon.edge_value, edge_mon.frame_end);
                  end
                  mismatches++;
               end
            end
            edge_count++;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_MODE: begin
                  cur_mode = csr_wdata[1:0];
               end
               REG_WIDTH: begin
                  reg_width = csr_wdata[WIDTH_W-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               REG_HEIGHT: begin
                  reg_height = csr_wdata[HEIGHT_W-1:0];
                  col_pos = 0;
                  row_pos = 0;
               end
               default: begin
               end
            endcase
         end
         if (pixel_mon.valid && pixel_mon.ready) begin
            filter_pixel(pixel_mon.pixel, pixel_mon.filler);
         end
      end
      failures <= mismatches;
      pending_edges <= expected_edges.size();
   end

endmodule

// File: bench/edge_filter_3x3_stream_unit_test.sv
// Testbench top of the 3x3 edge filter: drives pixel frames with bursts and gaps,
// stalls the edge channel and writes the registers between phases.
// Depends on efs_pkg, the channel interfaces, the filter and efs_edge_checker.
module edge_filter_3x3_stream_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import efs_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int RANDOM_ITEMS  = 180;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_LIMIT   = 10000;
   localparam int CYCLE_LIMIT   = 2000000;

   localparam logic [2:0] SET_MODE   = 3'b001 << REG_MODE;
   localparam logic [2:0] SET_WIDTH  = 3'b001 << REG_WIDTH;
   localparam logic [2:0] SET_HEIGHT = 3'b001 << REG_HEIGHT;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     failures;
   int                     pending_edges;
   int                     cycle_count = 0;
   int                     sent_items = 0;
   int                     burst_left;
   int                     frame_width;
   int                     frame_height;
   int                     pix_style;
   int                     pix_base;
   int                     stall_style;
   int                     stall_left = 0;
   int                     stall_phase = 0;

   efs_pixel_if req_if ();
   efs_edge_if  rsp_if ();

   edge_filter_3x3_stream_unit #(
      .MAX_WIDTH(MAX_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   efs_edge_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) edge_check (
      .clock         (clock),
      .reset         (reset),
      .pixel_mon     (req_if),
      .edge_mon      (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .failures      (failures),
      .pending_edges (pending_edges)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      stall_phase = (stall_phase + 1) % 5;
      case (stall_style)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_if.ready <= (stall_phase < 2);
         default: rsp_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   function automatic int clamp_size(input int value, input int hi);
      return (value == 0) ? 1 : ((value > hi) ? hi : value);
   endfunction

   function automatic pix_type next_pixel();
      int v;
      case (pix_style)
         0: v = $urandom_range(0, 255);
         1: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
         2: v = pix_base + $urandom_range(0, 7);
         default: v = pix_base + $urandom_range(0, 40);
      endcase
      return (v > 255) ? 8'hFF : pix_type'(v);
   endfunction

   task automatic send_pixel(input pix_type pixel, input logic filler);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 18);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_if.valid <= 1'b1;
      req_if.pixel <= pixel;
      req_if.filler <= filler;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      sent_items++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_edges != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] which, input logic [CSR_DATA_W-1:0] mode_word,
                            input logic [CSR_DATA_W-1:0] width_word,
                            input logic [CSR_DATA_W-1:0] height_word);
      if (which[REG_MODE]) begin
         write_reg(REG_MODE, mode_word);
      end
      if (which[REG_WIDTH]) begin
         write_reg(REG_WIDTH, width_word);
         frame_width = clamp_size(int'(width_word[WIDTH_W-1:0]), MAX_WIDTH);
      end
      if (which[REG_HEIGHT]) begin
         write_reg(REG_HEIGHT, height_word);
         frame_height = clamp_size(int'(height_word[HEIGHT_W-1:0]), MAX_HEIGHT);
      end
   endtask

   // A cut frame stops early so that the next register write restarts it mid-way.
   task automatic send_frame(input int filler_pct, input bit cut_short);
      int total;
      int count;
      total = frame_width * frame_height;
      count = cut_short ? $urandom_range(1, total + frame_width) : total + frame_width + 1;
      pix_style = $urandom_range(0, 3);
      pix_base = $urandom_range(0, 255);
      for (int k = 0; k < count; k++) begin
         if (k < total) begin
            send_pixel(next_pixel(), ($urandom_range(0, 99) < filler_pct));
         end else if ($urandom_range(0, 4) == 0) begin
            send_pixel(next_pixel(), 1'b0);
         end else begin
            send_pixel(pix_type'($urandom), 1'b1);
         end
      end
   endtask

   initial begin
      int w;
      int h;
      int pick;
      int random_start;
      int drain;
      req_if.valid = 1'b0;
      req_if.pixel = '0;
      req_if.filler = 1'b0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = REG_MODE;
      csr_wdata = '0;
      burst_left = 0;
      frame_width = WIDTH_RESET;
      frame_height = HEIGHT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a wide image, so these pixels only fill the line stores.
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hA5, 1'b0);
      wait_idle();

      configure(SET_WIDTH | SET_HEIGHT, '0, CSR_DATA_W'(2), CSR_DATA_W'(2));
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      repeat (3) send_pixel(8'h00, 1'b1);
      wait_idle();

      configure(SET_MODE, CSR_DATA_W'(MODE_PREWITT), '0, '0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'hFF, 1'b0);
      repeat (3) send_pixel(8'hFF, 1'b1);
      wait_idle();

      configure(SET_MODE | SET_WIDTH | SET_HEIGHT, CSR_DATA_W'(MODE_LAPLACE),
                CSR_DATA_W'(1), CSR_DATA_W'(2));
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      repeat (2) send_pixel(8'h00, 1'b1);
      wait_idle();

      configure(SET_MODE | SET_WIDTH | SET_HEIGHT, '1, CSR_DATA_W'(2), CSR_DATA_W'(1));
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'hFF, 1'b0);
      repeat (2) send_pixel(8'hFF, 1'b1);
      wait_idle();

      // Over-range sizes: only the start of each frame is sent, and the next write restarts it.
      configure(SET_MODE | SET_WIDTH | SET_HEIGHT, CSR_DATA_W'($urandom_range(0, 3)),
                CSR_DATA_W'(13'h07FF), CSR_DATA_W'(0));
      repeat (MAX_WIDTH + 41) send_pixel(next_pixel(), ($urandom_range(0, 99) < 3));
      wait_idle();
      configure(SET_MODE | SET_WIDTH | SET_HEIGHT, CSR_DATA_W'($urandom_range(0, 3)),
                CSR_DATA_W'(13'h1800), CSR_DATA_W'(13'h1FFF));
      repeat (60) send_pixel(next_pixel(), ($urandom_range(0, 99) < 3));
      wait_idle();
      configure(SET_WIDTH | SET_HEIGHT, '0, CSR_DATA_W'(4), CSR_DATA_W'(3));

      random_start = sent_items;
      while (sent_items < random_start + RANDOM_ITEMS) begin
         wait_idle();
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            w = $urandom_range(1, 8);
         end else if (pick < 8) begin
            w = $urandom_range(9, 40);
         end else begin
            w = $urandom_range(0, 3);
         end
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         configure(3'($urandom_range(1, 7)), CSR_DATA_W'($urandom),
                   {2'($urandom), WIDTH_W'(w)}, CSR_DATA_W'(h));
         repeat ($urandom_range(1, 3)) begin
            send_frame(($urandom_range(0, 1) != 0) ? 10 : 0, 1'b0);
         end
         if ($urandom_range(0, 4) == 0) begin
            send_frame(5, 1'b1);
         end
      end

      req_if.valid <= 1'b0;
      drain = 0;
      @(posedge clock);
      while (pending_edges != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending_edges == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
